[hdl/mws_pkg.sv]
// Shared types, register indexes and constants of the moisture watering sequencer.
`timescale 1ns / 1ps

package mws_pkg;

    localparam int VALVE_COUNT = 4;

    localparam int RAW_W   = 10;
    localparam int PCT_W   = 7;
    localparam int TIME_W  = 32;
    localparam int MASK_W  = 4;
    localparam int PHASE_W = 2;
    localparam int NUM_W   = 17;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 32;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WATER = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SOAK  = 2'd2;

    localparam logic [IDX_W-1:0] REG_LOW_PCT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_HIGH_PCT = 3'd1;
    localparam logic [IDX_W-1:0] REG_WATER_MS = 3'd2;
    localparam logic [IDX_W-1:0] REG_SOAK_MS  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRY_RAW  = 3'd4;
    localparam logic [IDX_W-1:0] REG_WET_RAW  = 3'd5;
    localparam logic [IDX_W-1:0] REG_VALVE_EN = 3'd6;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_status_t;

    // Valves at or above VALVE_COUNT are never driven.
    function automatic logic [MASK_W-1:0] valve_limit();
        logic [MASK_W-1:0] lim;
        for (int i = 0; i < MASK_W; i++)
        begin
            lim[i] = (i < VALVE_COUNT);
        end
        return lim;
    endfunction

endpackage

[hdl/moisture_watering_sequencer_core.sv]
// Top level of the moisture watering sequencer.
`timescale 1ns / 1ps

// Each input beat carries one ten-bit moisture sample and the current millisecond
// count; each one yields exactly one output beat with the valve drive, the phase
// after the step and the saturated moisture percent. The result passes through the
// scaling step, the bit-serial restoring divider that forms the percent and the
// commit step. The input is ready again in the cycle after the commit, so no new
// sample is accepted while one is in flight; a result left waiting at the output
// register holds the next commit until it is taken. Configuration registers are
// written through cfg_we, cfg_index and cfg_data and take effect at the next
// sample if the user writes them only between samples; the block itself does not
// enforce this.
module moisture_watering_sequencer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mws_pkg::IDX_W-1:0]     cfg_index,
    input  logic [mws_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mws_pkg::S_DATA_W-1:0]  s_tdata,   // raw_sample[9:0], now_ms[41:10]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mws_pkg::M_DATA_W-1:0]  m_tdata    // valve_drive[3:0], phase[5:4], moisture_pct[12:6]
);
    import mws_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mws_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[hdl/mws_ctrl.sv]
// Controller state machine: input capture, scaling, divide and result commit.
`timescale 1ns / 1ps

module mws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mws_pkg::dp_status_t status,
    output mws_pkg::ctrl_cmd_t  cmd
);
    import mws_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/mws_dp.sv]
// Datapath: configuration registers, percent scaling divider, sequencer state and output register.
`timescale 1ns / 1ps

module mws_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mws_pkg::IDX_W-1:0]     cfg_index,
    input  logic [mws_pkg::CFG_W-1:0]     cfg_data,
    input  logic [mws_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mws_pkg::M_DATA_W-1:0]  m_tdata,
    input  mws_pkg::ctrl_cmd_t            cmd,
    output mws_pkg::dp_status_t           status
);
    import mws_pkg::*;

    logic [PCT_W-1:0]   low_pct_reg;
    logic [PCT_W-1:0]   high_pct_reg;
    logic [TIME_W-1:0]  water_ms_reg;
    logic [TIME_W-1:0]  soak_ms_reg;
    logic [RAW_W-1:0]   dry_raw_reg;
    logic [RAW_W-1:0]   wet_raw_reg;
    logic [MASK_W-1:0]  valve_en_reg;

    logic [RAW_W-1:0]   raw_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [NUM_W-1:0]   quo_reg;
    logic [RAW_W-1:0]   rem_reg;
    logic [RAW_W-1:0]   den_mag_reg;
    logic               neg_reg;
    logic               den_zero_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [TIME_W-1:0]  last_switch_reg;
    logic [TIME_W-1:0]  last_switch_next;

    logic               out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic signed [RAW_W:0]   diff;
    logic signed [RAW_W:0]   den;
    logic signed [NUM_W:0]   num;
    logic [NUM_W-1:0]        num_mag;
    logic [RAW_W-1:0]        den_mag;
    logic [RAW_W:0]          trial;
    logic [PCT_W-1:0]        pct;
    logic [TIME_W-1:0]       elapsed;
    logic [MASK_W-1:0]       valve;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_pct_reg  <= 7'd30;
            high_pct_reg <= 7'd60;
            water_ms_reg <= 32'd10000;
            soak_ms_reg  <= 32'd30000;
            dry_raw_reg  <= 10'd0;
            wet_raw_reg  <= 10'd1023;
            valve_en_reg <= 4'hF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOW_PCT:  low_pct_reg  <= cfg_data[PCT_W-1:0];
                REG_HIGH_PCT: high_pct_reg <= cfg_data[PCT_W-1:0];
                REG_WATER_MS: water_ms_reg <= cfg_data[TIME_W-1:0];
                REG_SOAK_MS:  soak_ms_reg  <= cfg_data[TIME_W-1:0];
                REG_DRY_RAW:  dry_raw_reg  <= cfg_data[RAW_W-1:0];
                REG_WET_RAW:  wet_raw_reg  <= cfg_data[RAW_W-1:0];
                REG_VALVE_EN: valve_en_reg <= cfg_data[MASK_W-1:0];
                default:      ;
            endcase
        end
    end

    // Signed scaling ahead of the divider; the divide runs on magnitudes.
    always_comb
    begin
        diff    = $signed({1'b0, raw_reg}) - $signed({1'b0, dry_raw_reg});
        den     = $signed({1'b0, wet_raw_reg}) - $signed({1'b0, dry_raw_reg});
        num     = (NUM_W+1)'(diff) * $signed(18'sd100);
        num_mag = num[NUM_W] ? NUM_W'(-num) : num[NUM_W-1:0];
        den_mag = den[RAW_W] ? RAW_W'(-den) : den[RAW_W-1:0];
        trial   = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, den_mag_reg};
    end

    // Restoring divider, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg <= s_tdata[RAW_W-1:0];
            now_reg <= s_tdata[RAW_W +: TIME_W];
        end
        if (cmd.prep)
        begin
            quo_reg      <= num_mag;
            rem_reg      <= '0;
            den_mag_reg  <= den_mag;
            neg_reg      <= num[NUM_W] ^ den[RAW_W];
            den_zero_reg <= (den == '0);
        end
        else if (cmd.step)
        begin
            if (!trial[RAW_W])
            begin
                rem_reg <= trial[RAW_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[RAW_W-2:0], quo_reg[NUM_W-1]};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.prep)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Saturated percent and the sequencer step.
    always_comb
    begin
        if (den_zero_reg || neg_reg)
        begin
            pct = '0;
        end
        else if (quo_reg > NUM_W'(PCT_MAX))
        begin
            pct = PCT_MAX;
        end
        else
        begin
            pct = quo_reg[PCT_W-1:0];
        end

        elapsed          = now_reg - last_switch_reg;
        phase_next       = phase_reg;
        last_switch_next = last_switch_reg;
        case (phase_reg)
            PH_WATER:
            begin
                if (elapsed >= water_ms_reg)
                begin
                    last_switch_next = now_reg;
                    phase_next       = PH_SOAK;
                end
            end
            PH_SOAK:
            begin
                if (elapsed >= soak_ms_reg)
                begin
                    if (pct <= high_pct_reg)
                    begin
                        last_switch_next = now_reg;
                        phase_next       = PH_WATER;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (pct <= low_pct_reg)
                begin
                    last_switch_next = now_reg;
                    phase_next       = PH_WATER;
                end
            end
        endcase

        valve = (phase_next == PH_WATER) ? (valve_en_reg & valve_limit()) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            last_switch_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                phase_reg       <= phase_next;
                last_switch_reg <= last_switch_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= {3'b000, pct, phase_next, valve};
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign status.div_last = (cnt_reg == DIV_LAST);
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

[hdl/mws_checker.sv]
// Port-level assertions for the moisture watering sequencer and their binding.
`timescale 1ns / 1ps

module mws_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mws_pkg::M_DATA_W-1:0]  m_tdata
);
    import mws_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready again right after an accepted beat");

    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:4] != 2'd3)
        else $error("unused phase code on output");

    a_valve_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] == 4'd0) || (m_tdata[5:4] == PH_WATER))
        else $error("valves open outside watering");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[12:6] <= PCT_MAX)
        else $error("moisture percent above 100");

endmodule

bind moisture_watering_sequencer_core mws_checker u_mws_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
